// ===== rtl/core/gaussian_blur_window_core_macros.svh =====
// Assertion macros shared by the gaussian blur window checker.
`ifndef GAUSSIAN_BLUR_WINDOW_CORE_MACROS_SVH
`define GAUSSIAN_BLUR_WINDOW_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GBW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GBW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gbw_pkg.sv =====
// Types, constants and helper functions of the gaussian blur window core.
package gbw_pkg;

    localparam int KERNEL_RADIUS = 2;
    localparam int KSIZE         = 2 * KERNEL_RADIUS + 1;
    localparam int LINE_ROWS     = 2 * KERNEL_RADIUS;
    localparam int SLOT_W        = $clog2(LINE_ROWS);
    localparam int MAX_WIDTH     = 2048;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 16;
    localparam int FWIDTH_W   = 12;
    localparam int FHEIGHT_W  = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W   = PIX_W + WEIGHT_W;
    localparam int ROWSUM_W = PROD_W + $clog2(KSIZE);
    localparam int ACC_W    = ROWSUM_W + $clog2(KSIZE);
    localparam int FRAC_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH      = 3'd0,
        REG_FRAME_HEIGHT     = 3'd1,
        REG_WEIGHT_CENTER    = 3'd2,
        REG_WEIGHT_EDGE_NEAR = 3'd3,
        REG_WEIGHT_DIAG_NEAR = 3'd4,
        REG_WEIGHT_EDGE_FAR  = 3'd5,
        REG_WEIGHT_KNIGHT    = 3'd6,
        REG_WEIGHT_DIAG_FAR  = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        WC_CENTER,
        WC_EDGE_NEAR,
        WC_DIAG_NEAR,
        WC_EDGE_FAR,
        WC_KNIGHT,
        WC_DIAG_FAR,
        WC_ZERO
    } weight_class_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] blurred_pixel;
        logic             frame_last;
    } blur_t;

    function automatic weight_class_t weight_class(input int dy, input int dx);
        int ay;
        int ax;
        int lo;
        int hi;
        weight_class_t cls;
        ay = (dy < 0) ? -dy : dy;
        ax = (dx < 0) ? -dx : dx;
        lo = (ay < ax) ? ay : ax;
        hi = (ay < ax) ? ax : ay;
        cls = WC_ZERO;
        if (lo == 0 && hi == 0)
            cls = WC_CENTER;
        else if (lo == 0 && hi == 1)
            cls = WC_EDGE_NEAR;
        else if (lo == 1 && hi == 1)
            cls = WC_DIAG_NEAR;
        else if (lo == 0 && hi == 2)
            cls = WC_EDGE_FAR;
        else if (lo == 1 && hi == 2)
            cls = WC_KNIGHT;
        else if (lo == 2 && hi == 2)
            cls = WC_DIAG_FAR;
        return cls;
    endfunction

endpackage

// ===== rtl/core/gbw_ram.sv =====
// Generic single-port-write, registered-read RAM.
module gbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/gaussian_blur_window_core.sv =====
// Top level of the streaming 5x5 gaussian blur window core.
// Input channel pix (pix_valid / pix_stall): one grayscale pixel per item in
// raster order; frame_start marks row 0, column 0 of a new frame.
// Output channel blur (blur_valid / blur_stall): one item per interior center,
// frame_last set on the last interior result of the frame. Border centers
// give no item.
// Throughput: one pixel per cycle while pix_stall is low. An accepted pixel passes
// the line-store read, window shift, products, row sums and result register
// before blur_valid rises for its result.
// The line store is four row RAMs of 2048 entries; all four are read and one
// is written per item at the current column.
// Reset clears position, window and pipeline, and loads the default geometry
// and weights; it needs no clearing pass. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must do so only while the core is idle,
// which the core does not enforce. When blur_stall holds a valid result, the whole
// pipeline freezes and pix_stall rises in the same cycle.
module gaussian_blur_window_core
    import gbw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_t                  pix,
    output logic                  blur_valid,
    input  logic                  blur_stall,
    output blur_t                 blur,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [FWIDTH_W-1:0]  frame_width_reg;
    logic [FHEIGHT_W-1:0] frame_height_reg;
    logic [WEIGHT_W-1:0]  weight_center_reg;
    logic [WEIGHT_W-1:0]  weight_edge_near_reg;
    logic [WEIGHT_W-1:0]  weight_diag_near_reg;
    logic [WEIGHT_W-1:0]  weight_edge_far_reg;
    logic [WEIGHT_W-1:0]  weight_knight_reg;
    logic [WEIGHT_W-1:0]  weight_diag_far_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [FWIDTH_W-1:0]  w_eff;
    logic [FHEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]     c_cur;
    logic [ROW_W-1:0]     r_cur;
    logic [FWIDTH_W-1:0]  c_inc;
    logic [FHEIGHT_W-1:0] r_inc;
    logic [FHEIGHT_W-1:0] r_wrap;
    logic                 emit;
    logic                 last;

    logic adv;
    logic pix_acc;

    logic [PIX_W-1:0] line_rd [LINE_ROWS];

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [SLOT_W-1:0] s1_slot_reg;

    logic [PIX_W-1:0] win_col [LINE_ROWS];
    logic [PIX_W-1:0] win_reg [KSIZE][KSIZE];
    logic             win_valid_reg;
    logic             win_last_reg;

    logic [WEIGHT_W-1:0] wt [KSIZE][KSIZE];
    logic [PROD_W-1:0]   prod_reg [KSIZE][KSIZE];
    logic                prod_valid_reg;
    logic                prod_last_reg;

    logic [ROWSUM_W-1:0] rs_next [KSIZE];
    logic [ROWSUM_W-1:0] rs_reg [KSIZE];
    logic                rs_valid_reg;
    logic                rs_last_reg;

    logic [ACC_W-1:0]        acc;
    logic [ACC_W:0]          rounded;
    logic [ACC_W-FRAC_W:0]   scaled;
    logic [PIX_W-1:0]        sat_pixel;

    logic  blur_valid_reg;
    blur_t blur_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= FWIDTH_W'(640);
            frame_height_reg     <= FHEIGHT_W'(480);
            weight_center_reg    <= WEIGHT_W'(10000);
            weight_edge_near_reg <= WEIGHT_W'(6000);
            weight_diag_near_reg <= WEIGHT_W'(3700);
            weight_edge_far_reg  <= WEIGHT_W'(1300);
            weight_knight_reg    <= WEIGHT_W'(800);
            weight_diag_far_reg  <= WEIGHT_W'(200);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:      frame_width_reg      <= cfg_data[FWIDTH_W-1:0];
                REG_FRAME_HEIGHT:     frame_height_reg     <= cfg_data[FHEIGHT_W-1:0];
                REG_WEIGHT_CENTER:    weight_center_reg    <= cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_EDGE_NEAR: weight_edge_near_reg <= cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_DIAG_NEAR: weight_diag_near_reg <= cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_EDGE_FAR:  weight_edge_far_reg  <= cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_KNIGHT:    weight_knight_reg    <= cfg_data[WEIGHT_W-1:0];
                REG_WEIGHT_DIAG_FAR:  weight_diag_far_reg  <= cfg_data[WEIGHT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Handshake: freeze everything while a result waits
    assign adv       = !(blur_valid_reg && blur_stall);
    assign pix_acc   = pix_valid && adv;
    assign pix_stall = !adv;

    // Position of the incoming pixel
    always_comb
    begin
        w_eff = frame_width_reg;
        if (frame_width_reg == '0)
            w_eff = FWIDTH_W'(1);
        else if (frame_width_reg > FWIDTH_W'(MAX_WIDTH))
            w_eff = FWIDTH_W'(MAX_WIDTH);

        h_eff = frame_height_reg;
        if (frame_height_reg == '0)
            h_eff = FHEIGHT_W'(1);
        else if (frame_height_reg > FHEIGHT_W'(HEIGHT_LIMIT))
            h_eff = FHEIGHT_W'(HEIGHT_LIMIT);

        c_cur  = pix.frame_start ? '0 : col_reg;
        r_wrap = {1'b0, (pix.frame_start ? '0 : row_reg)};
        if (FWIDTH_W'(c_cur) >= w_eff)
        begin
            c_cur  = '0;
            r_wrap = r_wrap + FHEIGHT_W'(1);
        end
        if (r_wrap >= h_eff)
            r_wrap = '0;
        r_cur = r_wrap[ROW_W-1:0];

        c_inc = FWIDTH_W'(c_cur) + FWIDTH_W'(1);
        r_inc = FHEIGHT_W'(r_cur) + FHEIGHT_W'(1);
        emit  = (r_cur >= ROW_W'(LINE_ROWS)) && (c_cur >= COL_W'(LINE_ROWS));
        last  = (r_inc == h_eff) && (c_inc == w_eff);

        if (c_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line store: one RAM per buffered row, read before write at the same column
    for (genvar s = 0; s < LINE_ROWS; s++)
    begin : g_line
        gbw_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (pix_acc && (r_cur[SLOT_W-1:0] == SLOT_W'(s))),
            .waddr (c_cur),
            .wdata (pix.pixel_in),
            .re    (pix_acc),
            .raddr (c_cur),
            .rdata (line_rd[s])
        );
    end

    // Stage 1: item waits for its line-store reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= pix_acc;
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_emit_reg <= emit;
            s1_last_reg <= last;
            s1_px_reg   <= pix.pixel_in;
            s1_slot_reg <= r_cur[SLOT_W-1:0];
        end
    end

    // Rotate the row reads so window row y gets image row r-LINE_ROWS+y
    always_comb
    begin
        for (int y = 0; y < LINE_ROWS; y++)
        begin
            win_col[y] = line_rd[SLOT_W'(s1_slot_reg + SLOT_W'(y))];
        end
    end

    // Stage 2: window shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int y = 0; y < KSIZE; y++)
            begin
                for (int x = 0; x < KSIZE; x++)
                begin
                    win_reg[y][x] <= '0;
                end
            end
            win_valid_reg <= 1'b0;
            win_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            win_valid_reg <= s1_valid_reg && s1_emit_reg;
            win_last_reg  <= s1_last_reg;
            if (s1_valid_reg)
            begin
                for (int y = 0; y < KSIZE; y++)
                begin
                    for (int x = 0; x < KSIZE - 1; x++)
                    begin
                        win_reg[y][x] <= win_reg[y][x+1];
                    end
                end
                for (int y = 0; y < LINE_ROWS; y++)
                begin
                    win_reg[y][KSIZE-1] <= win_col[y];
                end
                win_reg[KSIZE-1][KSIZE-1] <= s1_px_reg;
            end
        end
    end

    // Weight per window tap
    always_comb
    begin
        for (int y = 0; y < KSIZE; y++)
        begin
            for (int x = 0; x < KSIZE; x++)
            begin
                unique case (weight_class(y - KERNEL_RADIUS, x - KERNEL_RADIUS))
                    WC_CENTER:    wt[y][x] = weight_center_reg;
                    WC_EDGE_NEAR: wt[y][x] = weight_edge_near_reg;
                    WC_DIAG_NEAR: wt[y][x] = weight_diag_near_reg;
                    WC_EDGE_FAR:  wt[y][x] = weight_edge_far_reg;
                    WC_KNIGHT:    wt[y][x] = weight_knight_reg;
                    WC_DIAG_FAR:  wt[y][x] = weight_diag_far_reg;
                    default:      wt[y][x] = '0;
                endcase
            end
        end
    end

    // Stage 3: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg <= win_valid_reg;
            prod_last_reg  <= win_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && win_valid_reg)
        begin
            for (int y = 0; y < KSIZE; y++)
            begin
                for (int x = 0; x < KSIZE; x++)
                begin
                    prod_reg[y][x] <= PROD_W'(win_reg[y][x]) * PROD_W'(wt[y][x]);
                end
            end
        end
    end

    // Stage 4: row sums
    always_comb
    begin
        for (int y = 0; y < KSIZE; y++)
        begin
            rs_next[y] = '0;
            for (int x = 0; x < KSIZE; x++)
            begin
                rs_next[y] = rs_next[y] + ROWSUM_W'(prod_reg[y][x]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_valid_reg <= 1'b0;
            rs_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            rs_valid_reg <= prod_valid_reg;
            rs_last_reg  <= prod_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && prod_valid_reg)
        begin
            rs_reg <= rs_next;
        end
    end

    // Final sum, round half up, saturate
    always_comb
    begin
        acc = '0;
        for (int y = 0; y < KSIZE; y++)
        begin
            acc = acc + ACC_W'(rs_reg[y]);
        end
        rounded   = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_W - 1));
        scaled    = rounded[ACC_W:FRAC_W];
        sat_pixel = (scaled > (ACC_W-FRAC_W+1)'(8'hFF)) ? 8'hFF : scaled[PIX_W-1:0];
    end

    // Stage 5: result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blur_valid_reg <= 1'b0;
        else if (adv)
            blur_valid_reg <= rs_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && rs_valid_reg)
        begin
            blur_reg.blurred_pixel <= sat_pixel;
            blur_reg.frame_last    <= rs_last_reg;
        end
    end

    assign blur_valid = blur_valid_reg;
    assign blur       = blur_reg;

endmodule

// ===== rtl/core/gbw_checker.sv =====
// Port-level checker for the gaussian blur window core, bound to the top level.
`include "gaussian_blur_window_core_macros.svh"

module gbw_checker
    import gbw_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  pix_valid,
    input logic  pix_stall,
    input logic  blur_valid,
    input logic  blur_stall,
    input blur_t blur
);

    `GBW_ASSERT_NEXT(a_blur_hold, blur_valid && blur_stall, blur_valid, "blur item dropped while stalled")

    `GBW_ASSERT_NEXT(a_blur_stable, blur_valid && blur_stall, $stable(blur), "blur item changed while stalled")

    `GBW_ASSERT_NOW(a_stall_cause, pix_stall, blur_valid && blur_stall, "pix stalled without a held result")

    `GBW_ASSERT_NOW(a_result_source, blur_valid && !$past(pix_stall, 1) && !$past(pix_stall, 2) && !$past(pix_stall, 3) && !$past(pix_stall, 4) && !$past(pix_stall, 5), $past(pix_valid && !pix_stall, 5), "result without a pixel five cycles back")

endmodule

bind gaussian_blur_window_core gbw_checker u_gbw_checker (.*);

// ===== tb/gaussian_blur_window_checker.sv =====
// Checker for the gaussian blur window core: predicts blurred pixels and compares them.
`timescale 1ns / 1ps

module gaussian_blur_window_checker
    import gbw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    input  logic                  pix_stall,
    input  pix_t                  pix,
    input  logic                  blur_valid,
    input  logic                  blur_stall,
    input  blur_t                 blur,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int REPORT_LIMIT = 10;

    logic [FWIDTH_W-1:0]  frame_width;
    logic [FHEIGHT_W-1:0] frame_height;
    logic [WEIGHT_W-1:0]  class_weight [8];
    logic [PIX_W-1:0]     line_rows [LINE_ROWS][MAX_WIDTH];
    logic [PIX_W-1:0]     window [KSIZE][KSIZE];
    int                   row_pos;
    int                   col_pos;
    int                   failures;
    blur_t                blurred_due [$];

    function automatic logic [WEIGHT_W-1:0] tap_weight(input int dy, input int dx);
        int near;
        int far;
        int tmp;
        near = (dy < 0) ? -dy : dy;
        far  = (dx < 0) ? -dx : dx;
        if (near > far)
        begin
            tmp  = near;
            near = far;
            far  = tmp;
        end
        if (far == 0)
            return class_weight[REG_WEIGHT_CENTER];
        if (far == 1)
            return (near == 0) ? class_weight[REG_WEIGHT_EDGE_NEAR]
                               : class_weight[REG_WEIGHT_DIAG_NEAR];
        if (near == 0)
            return class_weight[REG_WEIGHT_EDGE_FAR];
        if (near == 1)
            return class_weight[REG_WEIGHT_KNIGHT];
        return class_weight[REG_WEIGHT_DIAG_FAR];
    endfunction

    task automatic clear_model();
        frame_width  = 640;
        frame_height = 480;
        class_weight[REG_FRAME_WIDTH]      = '0;
        class_weight[REG_FRAME_HEIGHT]     = '0;
        class_weight[REG_WEIGHT_CENTER]    = 10000;
        class_weight[REG_WEIGHT_EDGE_NEAR] = 6000;
        class_weight[REG_WEIGHT_DIAG_NEAR] = 3700;
        class_weight[REG_WEIGHT_EDGE_FAR]  = 1300;
        class_weight[REG_WEIGHT_KNIGHT]    = 800;
        class_weight[REG_WEIGHT_DIAG_FAR]  = 200;
        for (int s = 0; s < LINE_ROWS; s++)
            for (int c = 0; c < MAX_WIDTH; c++)
                line_rows[s][c] = '0;
        for (int y = 0; y < KSIZE; y++)
            for (int x = 0; x < KSIZE; x++)
                window[y][x] = '0;
        row_pos  = 0;
        col_pos  = 0;
        failures = 0;
        blurred_due.delete();
    endtask

    task automatic load_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:  frame_width  = data[FWIDTH_W-1:0];
            REG_FRAME_HEIGHT: frame_height = data[FHEIGHT_W-1:0];
            default:          class_weight[idx] = data;
        endcase
    endtask

    task automatic slide_window(input pix_t item);
        int         w;
        int         h;
        int         r;
        int         c;
        logic [33:0] acc;
        logic [33:0] rounded;
        blur_t      res;
        w = frame_width;
        h = frame_height;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h == 0)
            h = 1;
        if (h > HEIGHT_LIMIT)
            h = HEIGHT_LIMIT;

        if (item.frame_start)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;

        for (int y = 0; y < KSIZE; y++)
            for (int x = 0; x < KSIZE - 1; x++)
                window[y][x] = window[y][x + 1];
        // window row y holds image row r - 4 + y
        for (int y = 0; y < KSIZE - 1; y++)
            window[y][KSIZE - 1] = line_rows[(r + y) % LINE_ROWS][c];
        window[KSIZE - 1][KSIZE - 1] = item.pixel_in;
        line_rows[r % LINE_ROWS][c] = item.pixel_in;

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;

        if (r >= LINE_ROWS && c >= LINE_ROWS)
        begin
            acc = '0;
            for (int y = 0; y < KSIZE; y++)
                for (int x = 0; x < KSIZE; x++)
                    acc += 34'(window[y][x]) *
                           34'(tap_weight(y - KERNEL_RADIUS, x - KERNEL_RADIUS));
            rounded = (acc + 34'd32768) >> 16;
            res.blurred_pixel = (rounded > 34'd255) ? 8'd255 : rounded[PIX_W-1:0];
            res.frame_last    = (r + 1 == h) && (c + 1 == w);
            blurred_due.push_back(res);
        end
    endtask

    task automatic check_blur(input blur_t got);
        blur_t want;
        if (blurred_due.size() == 0)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t: unexpected blur item: pixel %0d frame_last %0b",
                         $time, got.blurred_pixel, got.frame_last);
        end
        else
        begin
            want = blurred_due.pop_front();
            if (got.blurred_pixel !== want.blurred_pixel || got.frame_last !== want.frame_last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: blur mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                             $time, want.blurred_pixel, want.frame_last,
                             got.blurred_pixel, got.frame_last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (cfg_we)
                load_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (pix_valid && !pix_stall)
                slide_window(pix);
            if (blur_valid && !blur_stall)
                check_blur(blur);
        end
        pending    <= blurred_due.size();
        fail_count <= failures;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the gaussian blur window core: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb;
    import gbw_pkg::*;

    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int PREFILL_WIDTH  = 128;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  pix_valid;
    logic                  pix_stall;
    pix_t                  pix;
    logic                  blur_valid;
    logic                  blur_stall;
    blur_t                 blur;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    logic                  calm;
    int                    hold_requests;
    int                    idle_cycles;

    gaussian_blur_window_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .blur_valid (blur_valid),
        .blur_stall (blur_stall),
        .blur       (blur),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    gaussian_blur_window_checker blur_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .blur_valid (blur_valid),
        .blur_stall (blur_stall),
        .blur       (blur),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] value, input logic sof);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 27)
                gap++;
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.pixel_in    <= value;
        pix.frame_start <= sof;
        pix_valid       <= 1'b1;
        do
            @(posedge clk);
        while (pix_stall);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // drop valid, wait for every blurred pixel, then let the pipe empty
    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: random stall, with one long hold-off per request
    initial
    begin
        int holds_served;
        holds_served = 0;
        blur_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                blur_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            blur_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (blur_valid && !blur_stall) || cfg_we)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int                    sent;
        int                    phase_no;
        int                    count;
        int                    sel;
        int                    mode;
        logic                  restart;
        logic [CFG_DATA_W-1:0] value;
        logic [CFG_DATA_W-1:0] width_setting;

        rst_n         <= 1'b0;
        pix_valid     <= 1'b0;
        pix           <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_FRAME_WIDTH;
        cfg_data      <= '0;
        calm          <= 1'b0;
        hold_requests <= 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one frame with reset weights fills every line store column narrow frames reach
        write_reg(REG_FRAME_WIDTH, 16'(PREFILL_WIDTH));
        write_reg(REG_FRAME_HEIGHT, 16'd5);
        cfg_we <= 1'b0;
        for (int i = 0; i < 5 * PREFILL_WIDTH; i++)
            push_pixel(random_pixel(), i == 0);
        settle();

        // saturating 5x5 frame, then wrap into the next frame without frame_start
        for (int k = REG_WEIGHT_CENTER; k <= REG_WEIGHT_DIAG_FAR; k++)
            write_reg(cfg_reg_t'(k), 16'hFFFF);
        write_reg(REG_FRAME_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'd5);
        width_setting = 16'd5;
        cfg_we <= 1'b0;
        for (int i = 0; i < 28; i++)
            push_pixel((i == 12) ? 8'd0 : 8'd255, i == 0);
        settle();

        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm    <= (phase_no == 3);
            restart = ($urandom_range(99) < 60);
            count   = $urandom_range(260, 60);
            if (phase_no == 1 || phase_no == 9)
            begin
                value = 16'($urandom_range(10, 6));
                write_reg(REG_FRAME_WIDTH, value);
                width_setting = value;
                write_reg(REG_FRAME_HEIGHT, 16'd40);
                hold_requests <= hold_requests + 1;
                restart = 1'b1;
                count   = 300;
            end
            else
            begin
                if (phase_no == 3)
                    count = 400;
                if ($urandom_range(99) < 80)
                begin
                    sel = $urandom_range(99);
                    if (sel < 6)
                        value = 16'($urandom_range(4));
                    else if (sel < 12)
                        value = 16'($urandom_range(120, 30));
                    else if (sel < 15)
                        value = ($urandom_range(1)) ? 16'd4095 : 16'd2049;
                    else
                        value = 16'($urandom_range(16, 5));
                    write_reg(REG_FRAME_WIDTH, value);
                    width_setting = value;
                end
                if ($urandom_range(99) < 80)
                begin
                    sel = $urandom_range(99);
                    if (sel < 6)
                        value = 16'($urandom_range(4));
                    else if (sel < 9)
                        value = ($urandom_range(1)) ? 16'h1FFF : 16'd4096;
                    else
                        value = 16'($urandom_range(12, 5));
                    write_reg(REG_FRAME_HEIGHT, value);
                end
                mode = $urandom_range(9);
                for (int k = REG_WEIGHT_CENTER; k <= REG_WEIGHT_DIAG_FAR; k++)
                begin
                    if ($urandom_range(99) < 75)
                    begin
                        if (mode == 0)
                            value = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
                        else if (mode == 1)
                            value = 16'($urandom_range(65535));
                        else
                            value = 16'($urandom_range(65535 >> k));
                        write_reg(cfg_reg_t'(k), value);
                    end
                end
            end
            // start wide frames at the top so no emitted window reaches unfilled columns
            if (width_setting > 16'(PREFILL_WIDTH))
                restart = 1'b1;
            cfg_we <= 1'b0;
            for (int i = 0; i < count; i++)
                push_pixel(random_pixel(), (i == 0 && restart) || $urandom_range(79) == 0);
            settle();
            sent += count;
            phase_no++;
        end

        calm <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
